/* rtl/core/omls_pkg.sv */
// Shared types and constants for the octant midpoint line stepper.
// Holds the request and pixel word structs, the function codes and the octant codes.
// No dependencies.
package omls_pkg;

    // Coordinate width of the ports, and the widths of the internal walk state
    localparam int COORD_BITS = 12;
    localparam int WALK_BITS  = COORD_BITS + 1;
    localparam int DEC_BITS   = COORD_BITS + 4;
    localparam int STEP_BITS  = COORD_BITS + 3;

    // Request function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    // Octant (zone) codes
    typedef enum logic [2:0] {
        OCT_0,
        OCT_1,
        OCT_2,
        OCT_3,
        OCT_4,
        OCT_5,
        OCT_6,
        OCT_7
    } t_octant;

    // Request word
    typedef struct packed {
        logic                         func;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] stop_x;
        logic signed [COORD_BITS-1:0] stop_y;
    } t_in_word;

    // Pixel word
    typedef struct packed {
        logic                         pixel_valid;
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         last_pixel;
        logic [2:0]                   octant;
    } t_out_word;

endpackage

/* rtl/core/octant_midpoint_line_stepper_unit.sv */
// Octant midpoint line stepper: top level, single module.
// Depends on omls_pkg for the word structs, function codes and octant codes.
// Pixel pull engine. A load word (func FUNC_LOAD) takes two signed endpoints, classifies the
// line into one of eight octants, folds it into octant 0 and returns the start pixel. Each step
// word (func FUNC_STEP) returns the next pixel of the line in its original orientation; the end
// point carries last_pixel, and a step with no line active returns pixel_valid 0. A line whose
// endpoints coincide returns its single pixel with last_pixel set on the load. Every request
// word gives exactly one pixel word. The block takes one word per cycle and returns one pixel
// per cycle while pixel words are taken; an untaken pixel word stalls the request register.
// That register feeds the octant fold and the decision update, which write the walk state and
// the pixel register in the same cycle, so a pixel word passes the request register and then
// the pixel register. The decision/walk update loop closes through the walk state and sets
// the rate. A waiting pixel word does not stop a request entering an empty request register.
module octant_midpoint_line_stepper_unit
    import omls_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    // fold (x,y) into octant 0 coordinates; returns {u, v}
    function automatic logic [2*WALK_BITS-1:0] fold_pt(
        input t_octant                     z,
        input logic signed [WALK_BITS-1:0] x,
        input logic signed [WALK_BITS-1:0] y
    );
        logic signed [WALK_BITS-1:0] u;
        logic signed [WALK_BITS-1:0] v;
        case (z)
            OCT_0:   begin u = x;  v = y;  end
            OCT_1:   begin u = y;  v = x;  end
            OCT_2:   begin u = y;  v = -x; end
            OCT_3:   begin u = -x; v = y;  end
            OCT_4:   begin u = -x; v = -y; end
            OCT_5:   begin u = -y; v = -x; end
            OCT_6:   begin u = -y; v = x;  end
            default: begin u = x;  v = -y; end
        endcase
        return {u, v};
    endfunction

    // map octant 0 coordinates back to the true octant; returns {x, y}
    function automatic logic [2*WALK_BITS-1:0] unfold_pt(
        input t_octant                     z,
        input logic signed [WALK_BITS-1:0] u,
        input logic signed [WALK_BITS-1:0] v
    );
        logic signed [WALK_BITS-1:0] x;
        logic signed [WALK_BITS-1:0] y;
        case (z)
            OCT_0:   begin x = u;  y = v;  end
            OCT_1:   begin x = v;  y = u;  end
            OCT_2:   begin x = -v; y = u;  end
            OCT_3:   begin x = -u; y = v;  end
            OCT_4:   begin x = -u; y = -v; end
            OCT_5:   begin x = -v; y = -u; end
            OCT_6:   begin x = v;  y = -u; end
            default: begin x = u;  y = -v; end
        endcase
        return {x, y};
    endfunction

    // request register
    logic      r_in_valid;
    t_in_word  r_in_word;

    // pixel register
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word n_out_word;

    // walk state
    logic                         r_running;
    logic                         n_running;
    t_octant                      r_octant;
    t_octant                      n_octant;
    logic signed [WALK_BITS-1:0]  r_walk_x;
    logic signed [WALK_BITS-1:0]  n_walk_x;
    logic signed [WALK_BITS-1:0]  r_walk_y;
    logic signed [WALK_BITS-1:0]  n_walk_y;
    logic signed [WALK_BITS-1:0]  r_walk_end;
    logic signed [WALK_BITS-1:0]  n_walk_end;
    logic signed [DEC_BITS-1:0]   r_decision;
    logic signed [DEC_BITS-1:0]   n_decision;
    logic signed [STEP_BITS-1:0]  r_east_step;
    logic signed [STEP_BITS-1:0]  n_east_step;
    logic signed [STEP_BITS-1:0]  r_diag_step;
    logic signed [STEP_BITS-1:0]  n_diag_step;

    // load datapath
    logic signed [WALK_BITS-1:0]  sx;
    logic signed [WALK_BITS-1:0]  sy;
    logic signed [WALK_BITS-1:0]  ex;
    logic signed [WALK_BITS-1:0]  ey;
    logic signed [WALK_BITS-1:0]  dx;
    logic signed [WALK_BITS-1:0]  dy;
    logic [WALK_BITS-1:0]         ax_w;
    logic [WALK_BITS-1:0]         ay_w;
    logic [COORD_BITS-1:0]        ax;
    logic [COORD_BITS-1:0]        ay;
    logic                         x_major;
    t_octant                      ld_octant;
    logic [COORD_BITS-1:0]        du;
    logic [COORD_BITS-1:0]        dv;
    logic [2*WALK_BITS-1:0]       ld_start;
    logic signed [STEP_BITS-1:0]  dv_minus_du;

    // step datapath
    logic signed [WALK_BITS-1:0]  st_walk_x;
    logic signed [WALK_BITS-1:0]  st_walk_y;
    logic [2*WALK_BITS-1:0]       st_pix;

    logic advance;

    // handshake: request moves into the pixel register when it is free or drained
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // octant classification and fold of a load word
    always_comb begin
        sx = {r_in_word.start_x[COORD_BITS-1], r_in_word.start_x};
        sy = {r_in_word.start_y[COORD_BITS-1], r_in_word.start_y};
        ex = {r_in_word.stop_x[COORD_BITS-1], r_in_word.stop_x};
        ey = {r_in_word.stop_y[COORD_BITS-1], r_in_word.stop_y};
        dx = ex - sx;
        dy = ey - sy;
        ax_w = dx[WALK_BITS-1] ? WALK_BITS'(-dx) : WALK_BITS'(dx);
        ay_w = dy[WALK_BITS-1] ? WALK_BITS'(-dy) : WALK_BITS'(dy);
        ax = ax_w[COORD_BITS-1:0];
        ay = ay_w[COORD_BITS-1:0];
        x_major = (ax >= ay);

        if (x_major) begin
            if (!dx[WALK_BITS-1]) ld_octant = dy[WALK_BITS-1] ? OCT_7 : OCT_0;
            else                  ld_octant = dy[WALK_BITS-1] ? OCT_4 : OCT_3;
        end else begin
            if (!dx[WALK_BITS-1]) ld_octant = dy[WALK_BITS-1] ? OCT_6 : OCT_1;
            else                  ld_octant = dy[WALK_BITS-1] ? OCT_5 : OCT_2;
        end

        // folded deltas: major axis length and minor axis length
        du = x_major ? ax : ay;
        dv = x_major ? ay : ax;
        ld_start    = fold_pt(ld_octant, sx, sy);
        dv_minus_du = STEP_BITS'({1'b0, dv}) - STEP_BITS'({1'b0, du});
    end

    // midpoint step from the current walk state
    always_comb begin
        st_walk_x = r_walk_x + WALK_BITS'(1);
        st_walk_y = r_decision[DEC_BITS-1] ? r_walk_y : (r_walk_y + WALK_BITS'(1));
        st_pix    = unfold_pt(r_octant, st_walk_x, st_walk_y);
    end

    // next state and pixel word
    always_comb begin
        n_running   = r_running;
        n_octant    = r_octant;
        n_walk_x    = r_walk_x;
        n_walk_y    = r_walk_y;
        n_walk_end  = r_walk_end;
        n_decision  = r_decision;
        n_east_step = r_east_step;
        n_diag_step = r_diag_step;
        n_out_word  = '0;

        if (r_in_word.func == FUNC_LOAD) begin
            n_octant    = ld_octant;
            n_walk_x    = ld_start[2*WALK_BITS-1:WALK_BITS];
            n_walk_y    = ld_start[WALK_BITS-1:0];
            n_walk_end  = ld_start[2*WALK_BITS-1:WALK_BITS] + WALK_BITS'({1'b0, du});
            n_decision  = DEC_BITS'({dv, 1'b0}) - DEC_BITS'(du);
            n_east_step = STEP_BITS'({dv, 1'b0});
            n_diag_step = dv_minus_du <<< 1;
            // zero length line ends on its start pixel
            n_running   = (du != '0);
            // folding and unfolding the start point gives it back unchanged
            n_out_word.pixel_valid = 1'b1;
            n_out_word.pixel_x     = r_in_word.start_x;
            n_out_word.pixel_y     = r_in_word.start_y;
            n_out_word.last_pixel  = (du == '0);
            n_out_word.octant      = ld_octant;
        end else if (r_running) begin
            n_walk_x   = st_walk_x;
            n_walk_y   = st_walk_y;
            // tie at zero takes the diagonal step
            n_decision = r_decision[DEC_BITS-1]
                       ? r_decision + DEC_BITS'(r_east_step)
                       : r_decision + DEC_BITS'(r_diag_step);
            n_running  = !(st_walk_x >= r_walk_end);
            n_out_word.pixel_valid = 1'b1;
            n_out_word.pixel_x     = st_pix[WALK_BITS+COORD_BITS-1:WALK_BITS];
            n_out_word.pixel_y     = st_pix[COORD_BITS-1:0];
            n_out_word.last_pixel  = (st_walk_x >= r_walk_end);
            n_out_word.octant      = r_octant;
        end else begin
            // step with no line active
            n_out_word.octant = r_octant;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_running   <= 1'b0;
            r_octant    <= OCT_0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_running   <= n_running;
                r_octant    <= n_octant;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (advance) begin
            r_out_word  <= n_out_word;
            r_walk_x    <= n_walk_x;
            r_walk_y    <= n_walk_y;
            r_walk_end  <= n_walk_end;
            r_decision  <= n_decision;
            r_east_step <= n_east_step;
            r_diag_step <= n_diag_step;
        end
    end

endmodule
